// File: src/v4fw_pkg.sv
// ---------------------------------------------------------------------------
// v4fw_pkg
// Types and constants shared by the two-port IPv4 forwarder.
// ---------------------------------------------------------------------------
`default_nettype none

package v4fw_pkg;

	localparam int unsigned STORE_DEPTH = 37;
	localparam int unsigned ADDR_W      = 6;
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QPTR_W      = 2;

	localparam logic [5:0] STORE_LAST_IDX = 6'd37;
	localparam logic [5:0] ETH_WORDS      = 6'd7;
	localparam logic [5:0] MIN_WORDS      = 6'd17;
	localparam logic [6:0] MIN_BYTES      = 7'd34;
	localparam logic [5:0] IDX_SRC_HI     = 6'd3;
	localparam logic [5:0] IDX_SRC_MID    = 6'd4;
	localparam logic [5:0] IDX_SRC_LO     = 6'd5;
	localparam logic [5:0] IDX_ETYPE      = 6'd6;
	localparam logic [5:0] IDX_VER        = 6'd7;
	localparam logic [5:0] IDX_TTL        = 6'd11;
	localparam logic [5:0] IDX_CSUM       = 6'd12;
	localparam logic [5:0] IDX_DST_HI     = 6'd15;
	localparam logic [5:0] IDX_DST_LO     = 6'd16;
	localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
	localparam logic [15:0] TTL_ONE       = 16'h0100;
	localparam logic [3:0] IP_VERSION     = 4'd4;
	localparam logic [3:0] MIN_IHL        = 4'd5;

	typedef enum logic [3:0] {
		V_FWD       = 4'd0,
		V_SHORT     = 4'd1,
		V_OUTGOING  = 4'd2,
		V_NOT_IPV4  = 4'd3,
		V_OWN_MAC   = 4'd4,
		V_BAD_HDR   = 4'd5,
		V_NO_ROUTE  = 4'd6,
		V_SAME_PORT = 4'd7,
		V_TTL       = 4'd8
	} verdict_t;

	typedef enum logic [2:0] {
		REG_R0_NET  = 3'd0,
		REG_R0_MASK = 3'd1,
		REG_R0_NEXT = 3'd2,
		REG_R0_OWN  = 3'd3,
		REG_R1_NET  = 3'd4,
		REG_R1_MASK = 3'd5,
		REG_R1_NEXT = 3'd6,
		REG_R1_OWN  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] r0_net;
		logic [31:0] r0_mask;
		logic [47:0] r0_next;
		logic [47:0] r0_own;
		logic [31:0] r1_net;
		logic [31:0] r1_mask;
		logic [47:0] r1_next;
		logic [47:0] r1_own;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_COLLECT = 2'd0,
		PH_FWD     = 2'd1,
		PH_DROP    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_READ = 2'd1,
		B_EMIT = 2'd2
	} bstate_t;

	// hdr=1: emit header burst (word holds the new checksum), else one beat as is
	typedef struct packed {
		logic        hdr;
		logic [15:0] word;
		logic        last;
		logic        odd;
		logic        port;
		logic [3:0]  verdict;
		logic [5:0]  hlen;
	} qent_t;

endpackage

`default_nettype wire

// File: src/v4fw_ifs.sv
// ---------------------------------------------------------------------------
// v4fw_ifs
// Valid/ready channel interfaces: frame input, result output, register write.
// ---------------------------------------------------------------------------
`default_nettype none

interface v4fw_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] in_word;
	logic        in_last;
	logic        in_odd;
	logic        ingress_port;
	logic        outgoing;
	modport source (output valid, in_word, in_last, in_odd, ingress_port, outgoing,
		input ready);
	modport sink (input valid, in_word, in_last, in_odd, ingress_port, outgoing,
		output ready);
endinterface

interface v4fw_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_word;
	logic        out_last;
	logic        out_odd;
	logic        out_port;
	logic [3:0]  verdict;
	modport source (output valid, out_word, out_last, out_odd, out_port, verdict,
		input ready);
	modport sink (input valid, out_word, out_last, out_odd, out_port, verdict,
		output ready);
endinterface

interface v4fw_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/v4fw_ram.sv
// ---------------------------------------------------------------------------
// v4fw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module v4fw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 37
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/v4fw_queue.sv
// ---------------------------------------------------------------------------
// v4fw_queue
// Short command queue between the classifier and the emitter.
// ---------------------------------------------------------------------------
`default_nettype none

module v4fw_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire v4fw_pkg::qent_t push_data,
	input  wire logic            pop,
	output v4fw_pkg::qent_t      head,
	output logic                 full,
	output logic                 empty
);
	import v4fw_pkg::*;

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// File: src/v4fw_front.sv
// ---------------------------------------------------------------------------
// v4fw_front
// Accepts frame words, stores the header, runs the checks and route lookup,
// and queues header bursts, pass-through beats and verdicts.
// ---------------------------------------------------------------------------
`default_nettype none

module v4fw_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	v4fw_in_if.sink              rx,
	input  wire v4fw_pkg::cfg_t  cfg,
	input  wire logic            hdr_done,
	output logic                 hdr_busy,
	output logic                 ram_we,
	output logic [5:0]           ram_waddr,
	output logic [15:0]          ram_wdata,
	output logic                 q_push,
	output v4fw_pkg::qent_t      q_data,
	input  wire logic            q_full
);
	import v4fw_pkg::*;

	phase_t      phase_q;
	logic [5:0]  idx_q, hlen_q;
	logic [3:0]  reason_q;
	logic        port_q, ing_q, outg_q, hdr_busy_q;
	logic [15:0] sum_q, etype_q, w7_q;
	logic [47:0] src_q;
	logic [7:0]  ttl_q;
	logic [31:0] dst_q;

	logic        acc, first, ing_d, outg_d, odd_e, in_sum, m0, m1, port_late, decide;
	logic [15:0] w, etype_d, w7_d, term, sum_base, sum_d;
	logic [16:0] sum_add;
	logic [47:0] src_d;
	logic [7:0]  ttl_d;
	logic [31:0] dst_d;
	logic [5:0]  n, hlen_d;
	logic [6:0]  len;
	verdict_t    early_v, late_v, last_v, mid_v;

	assign w        = rx.in_word;
	assign first    = (idx_q == '0);
	assign acc      = rx.valid && rx.ready;
	assign rx.ready = !q_full && !(phase_q == PH_COLLECT && first && hdr_busy_q);
	assign hdr_busy = hdr_busy_q;

	// header fields as they stand including the current beat
	always_comb begin
		ing_d   = first ? rx.ingress_port : ing_q;
		outg_d  = first ? rx.outgoing : outg_q;
		src_d   = src_q;
		etype_d = (idx_q == IDX_ETYPE) ? w : etype_q;
		w7_d    = (idx_q == IDX_VER) ? w : w7_q;
		ttl_d   = (idx_q == IDX_TTL) ? w[15:8] : ttl_q;
		dst_d   = dst_q;
		if (idx_q == IDX_SRC_HI)  src_d[47:32] = w;
		if (idx_q == IDX_SRC_MID) src_d[31:16] = w;
		if (idx_q == IDX_SRC_LO)  src_d[15:0]  = w;
		if (idx_q == IDX_DST_HI)  dst_d[31:16] = w;
		if (idx_q == IDX_DST_LO)  dst_d[15:0]  = w;
	end

	assign n      = (idx_q < STORE_LAST_IDX) ? idx_q + 6'd1 : idx_q;
	assign hlen_d = (n > ETH_WORDS) ? ETH_WORDS + {1'b0, w7_d[11:8], 1'b0} : hlen_q;
	assign odd_e  = rx.in_last & rx.in_odd;
	assign len    = {n, 1'b0} - 7'(odd_e);

	always_comb begin
		if (outg_d)                                        early_v = V_OUTGOING;
		else if (etype_d != ETYPE_IPV4)                    early_v = V_NOT_IPV4;
		else if (src_d == cfg.r0_own || src_d == cfg.r1_own) early_v = V_OWN_MAC;
		else if (w7_d[15:12] != IP_VERSION || w7_d[11:8] < MIN_IHL) early_v = V_BAD_HDR;
		else                                               early_v = V_FWD;
	end

	assign m0 = (dst_d & cfg.r0_mask) == cfg.r0_net;
	assign m1 = (dst_d & cfg.r1_mask) == cfg.r1_net;
	// route 1 takes a tie only with the longer mask
	assign port_late = !m0 || (m1 && cfg.r1_mask > cfg.r0_mask);

	always_comb begin
		if (!m0 && !m1)              late_v = V_NO_ROUTE;
		else if (port_late == ing_d) late_v = V_SAME_PORT;
		else if (ttl_d <= 8'd1)      late_v = V_TTL;
		else                         late_v = V_FWD;
	end

	always_comb begin
		if (len < MIN_BYTES)              last_v = V_SHORT;
		else if (early_v != V_FWD)        last_v = early_v;
		else if (len < {hlen_d, 1'b0})    last_v = V_SHORT;
		else                              last_v = late_v;
	end

	assign decide = (n >= MIN_WORDS) && (early_v != V_FWD || n >= hlen_d);
	assign mid_v  = (early_v != V_FWD) ? early_v : late_v;

	// running ones-complement sum, TTL already decremented, checksum as zero
	always_comb begin
		if (idx_q == IDX_TTL)       term = w - TTL_ONE;
		else if (idx_q == IDX_CSUM) term = '0;
		else                        term = w;
	end
	assign in_sum   = (idx_q >= ETH_WORDS) && (idx_q < hlen_d);
	assign sum_base = first ? '0 : sum_q;
	assign sum_add  = {1'b0, sum_base} + {1'b0, term};
	assign sum_d    = in_sum ? sum_add[15:0] + 16'(sum_add[16]) : sum_base;

	assign ram_we    = acc && phase_q == PH_COLLECT && idx_q < STORE_LAST_IDX;
	assign ram_waddr = idx_q;
	assign ram_wdata = w;

	always_comb begin
		q_push         = 1'b0;
		q_data         = '0;
		q_data.hlen    = hlen_d;
		unique case (phase_q)
			PH_COLLECT: begin
				if (rx.in_last) begin
					q_push = acc;
					if (last_v == V_FWD) begin
						q_data.hdr  = 1'b1;
						q_data.word = ~sum_d;
						q_data.last = 1'b1;
						q_data.port = port_late;
					end else begin
						q_data.last    = 1'b1;
						q_data.verdict = last_v;
					end
				end else if (decide && mid_v == V_FWD) begin
					q_push      = acc;
					q_data.hdr  = 1'b1;
					q_data.word = ~sum_d;
					q_data.port = port_late;
				end
			end
			PH_FWD: begin
				q_push      = acc;
				q_data.word = w;
				q_data.last = rx.in_last;
				q_data.odd  = odd_e;
				q_data.port = port_q;
			end
			PH_DROP: begin
				q_push         = acc && rx.in_last;
				q_data.last    = 1'b1;
				q_data.verdict = reason_q;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_COLLECT) begin
			src_q   <= src_d;
			etype_q <= etype_d;
			w7_q    <= w7_d;
			ttl_q   <= ttl_d;
			dst_q   <= dst_d;
			sum_q   <= sum_d;
			hlen_q  <= hlen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COLLECT;
			idx_q      <= '0;
			reason_q   <= '0;
			port_q     <= 1'b0;
			ing_q      <= 1'b0;
			outg_q     <= 1'b0;
			hdr_busy_q <= 1'b0;
		end else begin
			if (hdr_done) hdr_busy_q <= 1'b0;
			if (q_push && q_data.hdr) hdr_busy_q <= 1'b1;
			if (acc) begin
				unique case (phase_q)
					PH_COLLECT: begin
						ing_q  <= ing_d;
						outg_q <= outg_d;
						port_q <= port_late;
						if (rx.in_last) begin
							idx_q <= '0;
						end else begin
							idx_q <= n;
							if (decide) begin
								if (mid_v == V_FWD) begin
									phase_q <= PH_FWD;
								end else begin
									phase_q  <= PH_DROP;
									reason_q <= mid_v;
								end
							end
						end
					end
					PH_FWD, PH_DROP: begin
						if (rx.in_last) begin
							phase_q <= PH_COLLECT;
							idx_q   <= '0;
						end
					end
					default: begin
						phase_q <= PH_COLLECT;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: src/v4fw_back.sv
// ---------------------------------------------------------------------------
// v4fw_back
// Drains the command queue: emits header bursts from the header RAM with
// rewritten MACs and checksum, and forwards single beats.
// ---------------------------------------------------------------------------
`default_nettype none

module v4fw_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire v4fw_pkg::cfg_t  cfg,
	input  wire v4fw_pkg::qent_t q_head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output logic [5:0]           ram_raddr,
	input  wire logic [15:0]     ram_rdata,
	output logic                 hdr_done,
	v4fw_out_if.source           tx
);
	import v4fw_pkg::*;

	bstate_t     state_q, state_d;
	qent_t       cmd_q;
	logic [5:0]  bidx_q;
	logic        ov_q, olast_q, oodd_q, oport_q;
	logic [15:0] oword_q, subst;
	logic [3:0]  overd_q;
	logic        out_free, ld_data, ld_hdr, at_end;
	logic [47:0] nm, om;

	assign out_free = !ov_q || tx.ready;
	assign at_end   = (bidx_q == cmd_q.hlen - 6'd1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty && out_free && q_head.hdr) state_d = B_READ;
			B_READ: state_d = B_EMIT;
			B_EMIT: if (out_free) state_d = at_end ? B_IDLE : B_READ;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == B_IDLE) && !q_empty && out_free;
		ld_data   = q_pop && !q_head.hdr;
		ld_hdr    = (state_q == B_EMIT) && out_free;
		hdr_done  = ld_hdr && at_end;
		ram_raddr = bidx_q;
	end

	assign nm = cmd_q.port ? cfg.r1_next : cfg.r0_next;
	assign om = cmd_q.port ? cfg.r1_own : cfg.r0_own;

	always_comb begin
		case (bidx_q)
			6'd0:     subst = nm[47:32];
			6'd1:     subst = nm[31:16];
			6'd2:     subst = nm[15:0];
			6'd3:     subst = om[47:32];
			6'd4:     subst = om[31:16];
			6'd5:     subst = om[15:0];
			IDX_TTL:  subst = ram_rdata - TTL_ONE;
			IDX_CSUM: subst = cmd_q.word;
			default:  subst = ram_rdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.hdr) begin
			cmd_q <= q_head;
		end
		if (ld_data) begin
			oword_q <= q_head.word;
			olast_q <= q_head.last;
			oodd_q  <= q_head.odd;
			oport_q <= q_head.port;
			overd_q <= q_head.verdict;
		end else if (ld_hdr) begin
			oword_q <= subst;
			olast_q <= cmd_q.last && at_end;
			oodd_q  <= 1'b0;
			oport_q <= cmd_q.port;
			overd_q <= V_FWD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			bidx_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_head.hdr) bidx_q <= '0;
			else if (ld_hdr)         bidx_q <= bidx_q + 6'd1;
			if (ld_data || ld_hdr) ov_q <= 1'b1;
			else if (tx.ready)     ov_q <= 1'b0;
		end
	end

	assign tx.valid    = ov_q;
	assign tx.out_word = oword_q;
	assign tx.out_last = olast_q;
	assign tx.out_odd  = oodd_q;
	assign tx.out_port = oport_q;
	assign tx.verdict  = overd_q;

endmodule

`default_nettype wire

// File: src/ipv4_two_port_forwarder.sv
// ---------------------------------------------------------------------------
// ipv4_two_port_forwarder
// Two-port IPv4 forwarder: header checks, longest-prefix route over two
// routes, TTL decrement, checksum and MAC rewrite.
//
//  channel  dir  beat contents
//  rx       in   in_word, in_last, in_odd, ingress_port, outgoing
//  tx       out  out_word, out_last, out_odd, out_port, verdict
//  cfg      in   index (register 0..7), data (low 32 or 48 bits used)
//
// rx takes one word per cycle except while the emitter still reads the
// previous frame's header RAM (first word of a new frame waits) or the
// 4-entry command queue is full.
// Header burst: each word is read from the RAM (B_READ), then loaded into the output register (B_EMIT).
// Pass-through and verdict beats go through the queue and the output register.
// Reset clears control state and the config registers; header RAM, queue entries and data registers are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv4_two_port_forwarder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	v4fw_in_if.sink    rx,
	v4fw_out_if.source tx,
	v4fw_cfg_if.sink   cfg
);
	import v4fw_pkg::*;

	cfg_t        cfg_q;
	logic        hdr_done, hdr_busy, ram_we, q_push, q_pop, q_full, q_empty;
	logic [5:0]  ram_waddr, ram_raddr;
	logic [15:0] ram_wdata, ram_rdata;
	qent_t       q_in, q_head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_R0_NET:  cfg_q.r0_net  <= cfg.data[31:0];
				REG_R0_MASK: cfg_q.r0_mask <= cfg.data[31:0];
				REG_R0_NEXT: cfg_q.r0_next <= cfg.data;
				REG_R0_OWN:  cfg_q.r0_own  <= cfg.data;
				REG_R1_NET:  cfg_q.r1_net  <= cfg.data[31:0];
				REG_R1_MASK: cfg_q.r1_mask <= cfg.data[31:0];
				REG_R1_NEXT: cfg_q.r1_next <= cfg.data;
				REG_R1_OWN:  cfg_q.r1_own  <= cfg.data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	v4fw_front u_front (
		.clk, .arst_n, .rx, .cfg(cfg_q), .hdr_done, .hdr_busy,
		.ram_we, .ram_waddr, .ram_wdata, .q_push, .q_data(q_in), .q_full
	);

	v4fw_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_hdr_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	v4fw_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
		.head(q_head), .full(q_full), .empty(q_empty)
	);

	v4fw_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_head, .q_empty, .q_pop,
		.ram_raddr, .ram_rdata, .hdr_done, .tx
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command queue overflow");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done |-> hdr_busy) else $error("header done without burst");
	a_no_ram_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && hdr_busy) |-> ram_waddr != 6'd0)
		else $error("header RAM overwritten during burst");
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.verdict != V_FWD) |-> tx.out_last)
		else $error("verdict beat without last");
`endif

endmodule

`default_nettype wire

// File: verif/ipv4_two_port_forwarder_tb.sv
// ---------------------------------------------------------------------------
// ipv4_two_port_forwarder_tb
// Self-checking bench for the two-port IPv4 forwarder. Random and directed
// frames go in, an internal forwarding model predicts every output beat, and
// the monitor compares each beat field by field with the predicted stream.
// ---------------------------------------------------------------------------
module ipv4_two_port_forwarder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import v4fw_pkg::*;

	typedef struct packed {
		logic [15:0] word;
		logic        last;
		logic        odd;
		logic        port;
		logic        outgoing;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] word;
		logic        last;
		logic        odd;
		logic        port;
		logic [3:0]  verdict;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	v4fw_in_if  rx ();
	v4fw_out_if tx ();
	v4fw_cfg_if cfg ();

	ipv4_two_port_forwarder DUT (.clk(clk), .arst_n(arst_n), .rx(rx), .tx(tx), .cfg(cfg));

	// model state
	cfg_t        routes;
	logic [15:0] hdr [STORE_DEPTH];
	int          widx, hlen_words;
	phase_t      phase;
	verdict_t    drop_why;
	logic        egress, f_ingress, f_outgoing;

	in_beat_t  pending_words [$];
	out_beat_t expected_beats [$];
	int        mismatches, beats_in, beats_out, frames_sent, idle_cycles, drops;
	int        verdict_seen [9];
	bit        stim_done;
	logic      in_acc;

	function automatic void push_beat(logic [15:0] w, logic l, logic o, logic p, verdict_t v);
		out_beat_t b;
		b.word = w; b.last = l; b.odd = o; b.port = p; b.verdict = v;
		expected_beats.push_back(b);
	endfunction

	function automatic verdict_t early_verdict();
		logic [47:0] src;
		if (f_outgoing)
			return V_OUTGOING;
		if (hdr[IDX_ETYPE] != ETYPE_IPV4)
			return V_NOT_IPV4;
		src = {hdr[IDX_SRC_HI], hdr[IDX_SRC_MID], hdr[IDX_SRC_LO]};
		if (src == routes.r0_own || src == routes.r1_own)
			return V_OWN_MAC;
		if (hdr[IDX_VER][15:12] != IP_VERSION || hdr[IDX_VER][11:8] < MIN_IHL)
			return V_BAD_HDR;
		return V_FWD;
	endfunction

	function automatic verdict_t route_verdict();
		logic [31:0] dst;
		logic m0, m1, p;
		dst = {hdr[IDX_DST_HI], hdr[IDX_DST_LO]};
		m0 = (dst & routes.r0_mask) == routes.r0_net;
		m1 = (dst & routes.r1_mask) == routes.r1_net;
		if (!m0 && !m1)
			return V_NO_ROUTE;
		p = m0 ? 1'b0 : 1'b1;
		if (m0 && m1 && routes.r1_mask > routes.r0_mask)
			p = 1'b1;
		egress = p;
		if (p == f_ingress)
			return V_SAME_PORT;
		if (hdr[IDX_TTL][15:8] <= 8'd1)
			return V_TTL;
		return V_FWD;
	endfunction

	function automatic void rewrite_header(logic is_last);
		logic [16:0] sum;
		logic [47:0] nm, om;
		nm = egress ? routes.r1_next : routes.r0_next;
		om = egress ? routes.r1_own : routes.r0_own;
		hdr[IDX_TTL] = hdr[IDX_TTL] - TTL_ONE;
		hdr[IDX_CSUM] = '0;
		sum = '0;
		for (int i = ETH_WORDS; i < hlen_words && i < STORE_DEPTH; i++) begin
			sum = sum + hdr[i];
			sum = {1'b0, sum[15:0]} + sum[16];
		end
		hdr[IDX_CSUM] = ~sum[15:0];
		for (int i = 0; i < 3; i++) begin
			hdr[i] = nm[47 - 16 * i -: 16];
			hdr[3 + i] = om[47 - 16 * i -: 16];
		end
		for (int i = 0; i < hlen_words && i < STORE_DEPTH; i++)
			push_beat(hdr[i], is_last && i + 1 == hlen_words, 1'b0, egress, V_FWD);
	endfunction

	function automatic void forward_word(in_beat_t b);
		logic     o;
		int       len;
		verdict_t v;
		o = b.last ? b.odd : 1'b0;
		if (phase == PH_FWD) begin
			push_beat(b.word, b.last, o, egress, V_FWD);
			if (b.last) begin
				phase = PH_COLLECT; widx = 0;
			end
			return;
		end
		if (phase == PH_DROP) begin
			if (b.last) begin
				push_beat('0, 1'b1, 1'b0, 1'b0, drop_why);
				phase = PH_COLLECT; widx = 0;
			end
			return;
		end
		if (widx == 0) begin
			f_ingress = b.port; f_outgoing = b.outgoing;
		end
		if (widx < STORE_DEPTH) begin
			hdr[widx] = b.word; widx++;
		end
		if (widx > ETH_WORDS)
			hlen_words = ETH_WORDS + 2 * hdr[IDX_VER][11:8];
		if (b.last) begin
			len = 2 * widx - o;
			widx = 0;
			if (len < MIN_BYTES)
				v = V_SHORT;
			else begin
				v = early_verdict();
				if (v == V_FWD)
					v = (len < 2 * hlen_words) ? V_SHORT : route_verdict();
			end
			if (v == V_FWD)
				rewrite_header(1'b1);
			else
				push_beat('0, 1'b1, 1'b0, 1'b0, v);
			return;
		end
		if (widx < MIN_WORDS)
			return;
		v = early_verdict();
		if (v == V_FWD) begin
			if (widx < hlen_words)
				return;
			v = route_verdict();
		end
		if (v != V_FWD) begin
			drop_why = v; phase = PH_DROP;
			return;
		end
		phase = PH_FWD;
		rewrite_header(1'b0);
	endfunction

	// frame builder
	task automatic queue_frame(int nwords, logic odd, logic port, logic og, logic [15:0] etype,
			logic [47:0] src, logic [7:0] ver_ihl, logic [7:0] ttl, logic [31:0] dst);
		in_beat_t b;
		logic [15:0] w;
		for (int i = 0; i < nwords; i++) begin
			w = 16'($urandom);
			case (i)
				3: w = src[47:32];
				4: w = src[31:16];
				5: w = src[15:0];
				6: w = etype;
				7: w = {ver_ihl, w[7:0]};
				11: w = {ttl, w[7:0]};
				15: w = dst[31:16];
				16: w = dst[15:0];
				default: ;
			endcase
			b.word = w;
			b.last = (i == nwords - 1);
			b.odd = b.last ? odd : 1'($urandom);
			b.port = (i == 0) ? port : 1'($urandom);
			b.outgoing = (i == 0) ? og : 1'($urandom);
			pending_words.push_back(b);
		end
		frames_sent++;
	endtask

	task automatic good_frame(int nwords, logic port, logic [31:0] dst);
		logic [3:0] ihl;
		ihl = 4'($urandom_range(5, 8));
		if (nwords < 0)
			nwords = 7 + 2 * ihl + $urandom_range(0, 4);
		queue_frame(nwords, 1'($urandom), port, 1'b0, ETYPE_IPV4, {16'h0a0a, 32'($urandom)},
			{IP_VERSION, ihl}, 8'($urandom_range(2, 255)), dst);
	endtask

	task automatic random_frame();
		int kind;
		logic [31:0] dst;
		logic p;
		kind = $urandom_range(0, 19);
		p = 1'($urandom);
		dst = $urandom_range(0, 1) ? (routes.r0_net | (32'($urandom) & ~routes.r0_mask))
			: (routes.r1_net | (32'($urandom) & ~routes.r1_mask));
		if ($urandom_range(0, 9) == 0)
			dst = $urandom;
		case (kind)
			0: queue_frame($urandom_range(1, 17), 1'($urandom), p, 1'b0, ETYPE_IPV4,
				48'($urandom), 8'h45, 8'd64, dst);
			1: queue_frame($urandom_range(17, 40), 1'($urandom), p, 1'($urandom),
				16'($urandom), {16'($urandom), 32'($urandom)}, 8'($urandom), 8'($urandom),
				32'($urandom));
			2: queue_frame($urandom_range(17, 30), 1'($urandom), p, 1'b0, ETYPE_IPV4,
				$urandom_range(0, 1) ? routes.r0_own : routes.r1_own, 8'h45, 8'd9, dst);
			3: queue_frame($urandom_range(17, 30), 1'($urandom), p, 1'b0, ETYPE_IPV4,
				48'h123456789abc, {4'($urandom), 4'($urandom_range(0, 5))}, 8'($urandom), dst);
			4: queue_frame($urandom_range(17, 40), 1'($urandom), p, 1'b0, ETYPE_IPV4,
				48'h123456789abc, {IP_VERSION, 4'($urandom_range(5, 15))},
				8'($urandom_range(0, 2)), dst);
			default: good_frame(-1, p, dst);
		endcase
	endtask

	task automatic write_reg(reg_idx_t idx, logic [47:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_R0_NET:  routes.r0_net = val[31:0];
			REG_R0_MASK: routes.r0_mask = val[31:0];
			REG_R0_NEXT: routes.r0_next = val;
			REG_R0_OWN:  routes.r0_own = val;
			REG_R1_NET:  routes.r1_net = val[31:0];
			REG_R1_MASK: routes.r1_mask = val[31:0];
			REG_R1_NEXT: routes.r1_next = val;
			REG_R1_OWN:  routes.r1_own = val;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic load_routes(logic [31:0] n0, logic [31:0] m0, logic [31:0] n1, logic [31:0] m1,
			logic [47:0] own0, logic [47:0] own1);
		write_reg(REG_R0_NET, {16'hffff, n0 & m0});
		write_reg(REG_R0_MASK, {16'hffff, m0});
		write_reg(REG_R0_NEXT, {16'($urandom), 32'($urandom)});
		write_reg(REG_R0_OWN, own0);
		write_reg(REG_R1_NET, {16'hffff, n1 & m1});
		write_reg(REG_R1_MASK, {16'hffff, m1});
		write_reg(REG_R1_NEXT, {16'($urandom), 32'($urandom)});
		write_reg(REG_R1_OWN, own1);
	endtask

	// idle between phases: everything drained, then a margin for a swallowed frame
	task automatic drain();
		while (pending_words.size() != 0 || expected_beats.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// driver; a beat taken at the last rising edge is never presented again
	int in_gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
			in_gap <= 0;
		end else if (rx.valid && !in_acc) begin
			// hold beat
		end else if (in_gap > 0) begin
			rx.valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_words.size() != 0) begin
			rx.valid <= 1'b1;
			{rx.in_word, rx.in_last, rx.in_odd, rx.ingress_port, rx.outgoing}
				<= pending_words[0];
			in_gap <= (frames_sent % 7 == 3) ? 0 : $urandom_range(0, 3);
		end else
			rx.valid <= 1'b0;
	end

	always @(posedge clk) begin
		in_acc <= arst_n && rx.valid && rx.ready;
		if (arst_n && rx.valid && rx.ready) begin
			forward_word(pending_words.pop_front());
			beats_in++;
		end
	end

	// monitor
	int out_gap;
	always @(negedge clk) begin
		if (!arst_n)
			tx.ready <= 1'b0;
		else if (out_gap > 0) begin
			tx.ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			tx.ready <= 1'b1;
			if (tx.valid)
				out_gap <= (frames_sent % 5 == 1) ? 0 : $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		out_beat_t want, got;
		if (arst_n && tx.valid && tx.ready) begin
			got = {tx.out_word, tx.out_last, tx.out_odd, tx.out_port, tx.verdict};
			beats_out++;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat %h", got);
			end else begin
				want = expected_beats.pop_front();
				if (got.last && got.verdict < 9)
					verdict_seen[got.verdict]++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat mismatch: word %h/%h last %b/%b odd %b/%b port %b/%b verdict %0d/%0d",
							want.word, got.word, want.last, got.last, want.odd, got.odd,
							want.port, got.port, want.verdict, got.verdict);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((rx.valid && rx.ready) || (tx.valid && tx.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else if (!stim_done || expected_beats.size() != 0 || pending_words.size() != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		rx.valid = 1'b0; rx.in_word = '0; rx.in_last = 1'b0; rx.in_odd = 1'b0;
		rx.ingress_port = 1'b0; rx.outgoing = 1'b0;
		tx.ready = 1'b0;
		cfg.valid = 1'b0; cfg.index = REG_R0_NET; cfg.data = '0;
		routes = '0;
		phase = PH_COLLECT; widx = 0; hlen_words = 0; egress = 1'b0;
		f_ingress = 1'b0; f_outgoing = 1'b0; drop_why = V_FWD;
		mismatches = 0; beats_in = 0; beats_out = 0; frames_sent = 0; idle_cycles = 0;
		stim_done = 0; in_gap = 0; out_gap = 0; drops = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: 10.1.0.0/16 on port 0, 10.0.0.0/8 on port 1
		load_routes(32'h0a010000, 32'hffff0000, 32'h0a000000, 32'hff000000,
			48'h020000000001, 48'h020000000002);
		good_frame(-1, 1'b1, 32'h0a01abcd);                  // longer prefix, port 0
		good_frame(-1, 1'b0, 32'h0a7f0001);                  // only route 1
		good_frame(27, 1'b0, 32'h0a010001);                  // back to ingress port
		good_frame(17, 1'b1, 32'h0a010002);                  // minimal frame, IHL may truncate
		queue_frame(17, 1'b1, 1'b0, 1'b0, ETYPE_IPV4, 48'h1, 8'h45, 8'd9, 32'h0a010003);
		queue_frame(1, 1'b1, 1'b0, 1'b0, 16'hffff, 48'h1, 8'h45, 8'd9, 32'h0);
		queue_frame(18, 1'b0, 1'b0, 1'b1, ETYPE_IPV4, 48'h1, 8'h45, 8'd9, 32'h0a010003);
		queue_frame(18, 1'b0, 1'b1, 1'b0, 16'h86dd, 48'h1, 8'h45, 8'd9, 32'h0a010003);
		queue_frame(18, 1'b0, 1'b1, 1'b0, ETYPE_IPV4, 48'h020000000002, 8'h45, 8'd9, 32'h0a010003);
		queue_frame(18, 1'b0, 1'b1, 1'b0, ETYPE_IPV4, 48'h1, 8'h64, 8'd9, 32'h0a010003);
		queue_frame(18, 1'b0, 1'b1, 1'b0, ETYPE_IPV4, 48'h1, 8'h44, 8'd9, 32'h0a010003);
		queue_frame(21, 1'b1, 1'b1, 1'b0, ETYPE_IPV4, 48'h1, 8'h4f, 8'd9, 32'h0a010003);
		queue_frame(40, 1'b1, 1'b1, 1'b0, ETYPE_IPV4, 48'hffffffffffff, 8'h4f, 8'hff,
			32'h0a010003);
		queue_frame(18, 1'b0, 1'b1, 1'b0, ETYPE_IPV4, 48'h1, 8'h45, 8'd9, 32'hc0000001);
		queue_frame(18, 1'b0, 1'b1, 1'b0, ETYPE_IPV4, 48'h1, 8'h45, 8'd1, 32'h0a010003);
		queue_frame(18, 1'b0, 1'b1, 1'b0, ETYPE_IPV4, 48'h1, 8'h45, 8'd0, 32'h0a010003);
		queue_frame(20, 1'b0, 1'b0, 1'b0, ETYPE_IPV4, 48'h0, 8'h45, 8'd2, 32'h0a7f0003);
		drain();

		// extremes: equal masks (route 0 wins), all-zero and all-ones settings
		load_routes(32'h0, 32'h0, 32'h0, 32'h0, 48'h0, 48'hffffffffffff);
		good_frame(-1, 1'($urandom), 32'($urandom));
		drain();
		load_routes(32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 48'hffffffffffff, 48'h0);
		good_frame(-1, 1'b1, 32'hffffffff);
		good_frame(-1, 1'b0, 32'hfffffffe);
		drain();

		for (int ph = 0; ph < 1; ph++) begin
			load_routes($urandom, 32'hffffffff << $urandom_range(0, 32),
				$urandom, 32'hffffffff << $urandom_range(0, 32),
				{16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
			for (int f = 0; f < 2; f++)
				random_frame();
			drain();
		end
		stim_done = 1;

		for (int k = 2; k < 9; k++)
			drops += verdict_seen[k];
		$display("frames %0d, beats in %0d, out %0d, verdict counts fwd %0d short %0d drop %0d",
			frames_sent, beats_in, beats_out, verdict_seen[0], verdict_seen[1], drops);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
